/* rtl/jdc_pkg.sv */
`default_nettype none
package jdc_pkg;

  localparam int SAMPLE_W = 10;
  localparam int DZ_W     = 9;
  localparam int THR_W    = 7;
  localparam int DIR_W    = 3;
  localparam int SPEED_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [SAMPLE_W:0] CENTER = 11'd512;

  localparam logic [DIR_W-1:0] DIR_STOP      = 3'd0;
  localparam logic [DIR_W-1:0] DIR_IDLE      = 3'd1;
  localparam logic [DIR_W-1:0] DIR_FORWARD   = 3'd2;
  localparam logic [DIR_W-1:0] DIR_BACKWARD  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_LEFT      = 3'd4;
  localparam logic [DIR_W-1:0] DIR_RIGHT     = 3'd5;
  localparam logic [DIR_W-1:0] DIR_ROT_LEFT  = 3'd6;
  localparam logic [DIR_W-1:0] DIR_ROT_RIGHT = 3'd7;

  localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_FWD_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_TURN_MIN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_TURN_MIN = 2'd3;

  typedef struct packed {
    logic [DZ_W-1:0]  dead_zone;
    logic [THR_W-1:0] rotate_forward_limit;
    logic [THR_W-1:0] rotate_turn_min;
    logic [THR_W-1:0] curve_turn_min;
  } cfg_t;

  typedef struct packed {
    logic                enable_button;
    logic [SAMPLE_W-1:0] y_sample;
    logic [SAMPLE_W-1:0] x_sample;
  } sample_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [DIR_W-1:0]   direction;
  } drive_t;

endpackage
`default_nettype wire

/* rtl/joystick_drive_classifier.sv */
`default_nettype none
// Joystick drive classifier. Each input word carries one x/y reading pair and the
// enable button; each produces exactly one result word with direction, speed 0..100
// and a changed flag against the previous result's direction. The block is a
// two-register pipeline (input register, then result register) and sustains one
// word per cycle while out_tready stays high; an accepted word waits in the input
// register and moves into the result register once that is empty or being taken.
// Configuration writes are always accepted (cfg_ready is tied high) and must only
// be issued while no words are in flight. Direction history resets to stop.
module joystick_drive_classifier (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [9:0] x_sample, [19:10] y_sample, [20] enable_button, [23:21] zero
  input  wire logic [23:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [2:0] direction, [9:3] speed, [10] changed, [15:11] zero
  output logic      [15:0] out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [jdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [jdc_pkg::CFG_DATA_W-1:0] cfg_data
);

  jdc_pkg::cfg_t    cfg_r;
  jdc_pkg::sample_t smp_r;
  logic             smp_vld_r;
  jdc_pkg::drive_t  drive;
  logic [jdc_pkg::DIR_W-1:0]   last_dir_r;
  logic [jdc_pkg::DIR_W-1:0]   out_dir_r;
  logic [jdc_pkg::SPEED_W-1:0] out_speed_r;
  logic                        out_chg_r;
  logic                        out_vld_r;
  logic                        out_load;
  logic                        in_acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dead_zone            <= 9'd60;
      cfg_r.rotate_forward_limit <= 7'd25;
      cfg_r.rotate_turn_min      <= 7'd10;
      cfg_r.curve_turn_min       <= 7'd50;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        jdc_pkg::CFG_DEAD_ZONE:      cfg_r.dead_zone            <= cfg_data;
        jdc_pkg::CFG_ROT_FWD_LIMIT:  cfg_r.rotate_forward_limit <= cfg_data[6:0];
        jdc_pkg::CFG_ROT_TURN_MIN:   cfg_r.rotate_turn_min      <= cfg_data[6:0];
        jdc_pkg::CFG_CURVE_TURN_MIN: cfg_r.curve_turn_min       <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // result register frees up when empty or taken; input stage moves into it then
  assign out_load  = smp_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !smp_vld_r || out_load;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_vld_r <= 1'b0;
    end else if (in_tready) begin
      smp_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp_r <= in_tdata[20:0];
    end
  end

  jdc_classify u_classify (
    .sample (smp_r),
    .cfg    (cfg_r),
    .drive  (drive)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      last_dir_r <= jdc_pkg::DIR_STOP;
    end else begin
      if (out_load) begin
        out_vld_r  <= 1'b1;
        last_dir_r <= drive.direction;
      end else if (out_tready) begin
        out_vld_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_dir_r   <= drive.direction;
      out_speed_r <= drive.speed;
      out_chg_r   <= drive.direction != last_dir_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, out_chg_r, out_speed_r, out_dir_r};

  a_hist_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_dir_r == last_dir_r)
    else $error("direction history out of step with result register");

  a_idle_no_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_dir_r == jdc_pkg::DIR_IDLE) |-> out_speed_r == '0)
    else $error("idle result carries nonzero speed");

  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_speed_r <= jdc_pkg::SPEED_MAX)
    else $error("speed above full scale");

  a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_vld_r && out_chg_r == (out_dir_r != $past(last_dir_r)))
    else $error("loaded result missing or changed flag wrong");

endmodule
`default_nettype wire

/* rtl/jdc_axis.sv */
`default_nettype none
module jdc_axis (
  input  wire logic [jdc_pkg::SAMPLE_W-1:0] sample,
  input  wire logic [jdc_pkg::DZ_W-1:0]     dead_zone,
  output logic      [jdc_pkg::SPEED_W-1:0]  mag,
  output logic                              pos
);

  logic [jdc_pkg::SAMPLE_W:0]   hi_thr;
  logic [jdc_pkg::SAMPLE_W:0]   lo_sum;
  logic                         neg;
  logic [15:0]                  p_hi;
  logic [jdc_pkg::SPEED_W-1:0]  q0;
  logic [9:0]                   rem;
  logic [jdc_pkg::SPEED_W-1:0]  q_hi;
  logic [jdc_pkg::SAMPLE_W-1:0] d_lo;
  logic [15:0]                  p_lo;

  assign hi_thr = jdc_pkg::CENTER + {2'b00, dead_zone};
  assign lo_sum = {1'b0, sample} + {2'b00, dead_zone};
  assign pos    = {1'b0, sample} > hi_thr;
  assign neg    = lo_sum < jdc_pkg::CENTER;

  // above center: offset is the low 9 bits; divide by 511 as p>>9 plus one correction
  assign p_hi = {7'd0, sample[8:0]} * 16'd100;
  assign q0   = p_hi[15:9];
  assign rem  = {1'b0, p_hi[8:0]} + {3'd0, q0};
  assign q_hi = (rem >= 10'd511) ? q0 + 7'd1 : q0;

  // below center: divide by 512 is a shift
  assign d_lo = 10'd512 - sample;
  assign p_lo = {6'd0, d_lo} * 16'd100;

  always_comb begin
    priority if (pos) begin
      mag = q_hi;
    end else if (neg) begin
      mag = p_lo[15:9];
    end else begin
      mag = '0;
    end
  end

endmodule
`default_nettype wire

/* rtl/jdc_classify.sv */
`default_nettype none
module jdc_classify (
  input  wire jdc_pkg::sample_t sample,
  input  wire jdc_pkg::cfg_t    cfg,
  output jdc_pkg::drive_t       drive
);

  logic [jdc_pkg::SPEED_W-1:0] fmag;
  logic [jdc_pkg::SPEED_W-1:0] tmag;
  logic                        fpos;
  logic                        tpos;
  logic [jdc_pkg::SPEED_W-1:0] larger;

  jdc_axis u_fwd (
    .sample    (sample.y_sample),
    .dead_zone (cfg.dead_zone),
    .mag       (fmag),
    .pos       (fpos)
  );

  jdc_axis u_turn (
    .sample    (sample.x_sample),
    .dead_zone (cfg.dead_zone),
    .mag       (tmag),
    .pos       (tpos)
  );

  assign larger = (fmag > tmag) ? fmag : tmag;

  always_comb begin
    drive.direction = jdc_pkg::DIR_STOP;
    drive.speed     = '0;
    priority if (!sample.enable_button) begin
      drive.direction = jdc_pkg::DIR_IDLE;
    end else if (fmag != '0 || tmag != '0) begin
      drive.speed = (larger > jdc_pkg::SPEED_MAX) ? jdc_pkg::SPEED_MAX : larger;
      priority if (fmag < cfg.rotate_forward_limit && tmag > cfg.rotate_turn_min) begin
        drive.direction = tpos ? jdc_pkg::DIR_ROT_RIGHT : jdc_pkg::DIR_ROT_LEFT;
      end else if (fmag != '0) begin
        if (tmag > cfg.curve_turn_min) begin
          drive.direction = tpos ? jdc_pkg::DIR_RIGHT : jdc_pkg::DIR_LEFT;
        end else begin
          drive.direction = fpos ? jdc_pkg::DIR_FORWARD : jdc_pkg::DIR_BACKWARD;
        end
      end else if (tmag > cfg.rotate_turn_min) begin
        drive.direction = tpos ? jdc_pkg::DIR_ROT_RIGHT : jdc_pkg::DIR_ROT_LEFT;
      end else begin
        // small pure turn stays stopped but still reports its magnitude
        drive.direction = jdc_pkg::DIR_STOP;
      end
    end else begin
      drive.direction = jdc_pkg::DIR_STOP;
    end
  end

endmodule
`default_nettype wire

/* tb/sv/joystick_drive_classifier_tb.sv */
`default_nettype none
module joystick_drive_classifier_tb;
  import jdc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 250;
  localparam int NUM_PHASES  = 7;

  // result word as it sits in out_tdata[10:0], lowest field last
  typedef struct packed {
    logic               changed;
    logic [SPEED_W-1:0] speed;
    logic [DIR_W-1:0]   direction;
  } drive_word_t;

  class drive_ledger;
    int unsigned dead_zone     = 60;
    int unsigned rot_fwd_limit = 25;
    int unsigned rot_turn_min  = 10;
    int unsigned curve_turn_min = 50;
    logic [DIR_W-1:0] last_dir = DIR_STOP;
    drive_word_t due_drives[$];
    int errors = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_DEAD_ZONE:      dead_zone      = val;
        CFG_ROT_FWD_LIMIT:  rot_fwd_limit  = val[THR_W-1:0];
        CFG_ROT_TURN_MIN:   rot_turn_min   = val[THR_W-1:0];
        CFG_CURVE_TURN_MIN: curve_turn_min = val[THR_W-1:0];
        default: ;
      endcase
    endfunction

    // magnitude 0..100 of one axis after the dead band
    function int axis_mag(int v, output bit pos);
      int mid;
      mid = int'(CENTER);
      pos = 1'b0;
      if (v > mid + int'(dead_zone)) begin
        pos = 1'b1;
        return ((v - mid) * 100) / 511;
      end
      if (v + int'(dead_zone) < mid)
        return ((mid - v) * 100) / 512;
      return 0;
    endfunction

    function drive_word_t classify_drive(sample_t s);
      drive_word_t w;
      int fmag, tmag, spd;
      bit fpos, tpos;
      logic [DIR_W-1:0] dir;
      dir = DIR_STOP;
      spd = 0;
      if (!s.enable_button) begin
        dir = DIR_IDLE;
      end else begin
        fmag = axis_mag(int'(s.y_sample), fpos);
        tmag = axis_mag(int'(s.x_sample), tpos);
        if (fmag != 0 || tmag != 0) begin
          spd = (fmag > tmag) ? fmag : tmag;
          if (spd > int'(SPEED_MAX)) spd = int'(SPEED_MAX);
          if (fmag < int'(rot_fwd_limit) && tmag > int'(rot_turn_min))
            dir = tpos ? DIR_ROT_RIGHT : DIR_ROT_LEFT;
          else if (fmag != 0) begin
            if (tmag > int'(curve_turn_min))
              dir = tpos ? DIR_RIGHT : DIR_LEFT;
            else
              dir = fpos ? DIR_FORWARD : DIR_BACKWARD;
          end else if (tmag > int'(rot_turn_min))
            dir = tpos ? DIR_ROT_RIGHT : DIR_ROT_LEFT;
          // small pure turn stays stop but keeps its speed
        end
      end
      w.direction = dir;
      w.speed     = spd[SPEED_W-1:0];
      w.changed   = (dir != last_dir);
      last_dir    = dir;
      return w;
    endfunction

    function void note_sample(sample_t s);
      due_drives.push_back(classify_drive(s));
    endfunction

    function void check_drive(logic [15:0] data);
      drive_word_t got, want;
      got = data[10:0];
      if (due_drives.size() == 0) begin
        $error("result word %h arrived with no prediction pending", data);
        errors++;
        return;
      end
      want = due_drives.pop_front();
      if (got.direction !== want.direction) begin
        $error("direction mismatch: expected %0d, got %0d", want.direction, got.direction);
        errors++;
      end
      if (got.speed !== want.speed) begin
        $error("speed mismatch: expected %0d, got %0d", want.speed, got.speed);
        errors++;
      end
      if (got.changed !== want.changed) begin
        $error("changed mismatch: expected %0d, got %0d", want.changed, got.changed);
        errors++;
      end
    endfunction

    function int pending();
      return due_drives.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  drive_ledger ledger = new();
  int tx_gap_max = 11;
  int rx_gap_max = 11;
  bit hold_req = 1'b0;
  int stall_cnt = 0;

  joystick_drive_classifier i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) ledger.set_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) ledger.note_sample(sample_t'(in_tdata[20:0]));
      if (out_tvalid && out_tready) ledger.check_drive(out_tdata);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    int gap;
    int n;
    n = 0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (n % 128 == 0) rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
      gap = $urandom_range(0, rx_gap_max);
      if (gap != 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
      n++;
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y,
                             input logic btn);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {3'b000, btn, y, x};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (ledger.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    wait_drained();
    // pipeline is two deep, let it settle
    repeat (3) @(negedge clk);
    cfg_index = idx;
    cfg_data  = val[CFG_DATA_W-1:0];
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_settings(input int dz, input int rfl, input int rtm, input int ctm);
    write_reg(CFG_DEAD_ZONE, dz);
    write_reg(CFG_ROT_FWD_LIMIT, rfl);
    write_reg(CFG_ROT_TURN_MIN, rtm);
    write_reg(CFG_CURVE_TURN_MIN, ctm);
  endtask

  // readings clustered on band edges, threshold crossings, the range ends and the center, plus plain random
  function automatic logic [SAMPLE_W-1:0] pick_reading();
    int v, t, dz;
    dz = ledger.dead_zone;
    t = 0;
    case ($urandom_range(0, 6))
      0, 1: v = $urandom_range(0, 1023);
      2: v = 512 + dz + int'($urandom_range(0, 2)) - 1;
      3: v = 512 - dz - int'($urandom_range(0, 2)) + 1;
      4: v = $urandom_range(0, 1) ? int'($urandom_range(0, 1)) : int'($urandom_range(1022, 1023));
      5: v = 512 + int'($urandom_range(0, 40)) - 20;
      default: begin
        case ($urandom_range(0, 2))
          0: t = ledger.rot_fwd_limit;
          1: t = ledger.rot_turn_min;
          default: t = ledger.curve_turn_min;
        endcase
        v = 512 + (t * 512) / 100 + int'($urandom_range(0, 6)) - 3;
        if ($urandom_range(0, 1)) v = 1024 - v;
      end
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic random_phase(input int n, input bit with_hold);
    logic [SAMPLE_W-1:0] x, y;
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
      if (with_hold && i == 40) begin
        tx_gap_max = 0;
        hold_req = 1'b1;
      end
      if (i == n / 2) wait_drained();
      x = pick_reading();
      y = pick_reading();
      send_sample(x, y, $urandom_range(0, 7) != 0);
    end
  endtask

  initial begin
    int dz;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // reset thresholds: dead band 60, rotate 25/10, curve 50
    send_sample(10'd512, 10'd512, 1'b1);   // centered, stop
    send_sample(10'd0, 10'd0, 1'b0);       // button released
    send_sample(10'd1023, 10'd1023, 1'b0);
    send_sample(10'd1023, 10'd1023, 1'b1); // full forward with hard turn
    send_sample(10'd512, 10'd1023, 1'b1);
    send_sample(10'd512, 10'd0, 1'b1);
    send_sample(10'd0, 10'd512, 1'b1);     // rotate in place
    send_sample(10'd1023, 10'd512, 1'b1);
    send_sample(10'd0, 10'd1023, 1'b1);
    send_sample(10'd0, 10'd0, 1'b1);
    send_sample(10'd1023, 10'd600, 1'b1);  // slow forward, rotation wins
    send_sample(10'd700, 10'd1023, 1'b1);  // mild turn stays forward
    send_sample(10'd572, 10'd452, 1'b1);   // just inside the band
    send_sample(10'd573, 10'd451, 1'b1);   // just outside the band
    send_sample(10'd451, 10'd512, 1'b1);

    // no dead band: small pure turn keeps stop with nonzero speed
    write_reg(CFG_DEAD_ZONE, 0);
    send_sample(10'd520, 10'd512, 1'b1);
    send_sample(10'd513, 10'd512, 1'b1);
    send_sample(10'd504, 10'd512, 1'b1);
    send_sample(10'd512, 10'd513, 1'b1);

    // widest band covers the whole high side; on the low side only a reading of 0 lies outside
    write_reg(CFG_DEAD_ZONE, 511);
    send_sample(10'd1, 10'd1023, 1'b1);
    send_sample(10'd0, 10'd1023, 1'b1);
    send_sample(10'd1023, 10'd0, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: apply_settings(0, 0, 0, 0);
        1: apply_settings(511, 100, 100, 100);
        2: apply_settings(60, 25, 10, 50);
        3: apply_settings(0, 100, 0, 100);
        default: begin
          dz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 120);
          apply_settings(dz, $urandom_range(0, 100), $urandom_range(0, 100),
                         $urandom_range(0, 100));
        end
      endcase
      random_phase(PHASE_ITEMS, p == 2);
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (ledger.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
